### hdl/scr_pkg.sv
// Shared types, widths and helpers for the spring constraint relaxation block.
// Used by every module under hdl/. Depends on nothing.

package scr_pkg;

    // Field widths
    localparam int POS_W   = 20;              // signed Q12.8 position
    localparam int REST_W  = 19;              // unsigned Q11.8 rest length
    localparam int STIFF_W = 17;              // unsigned Q1.16 stiffness
    localparam int FRAC_W  = 16;              // stiffness fraction bits

    // Datapath widths
    localparam int MAG_W   = POS_W + 1;       // |b - a| per axis
    localparam int SQ_W    = 2 * MAG_W;       // dx*dx + dy*dy
    localparam int DIST_W  = SQ_W / 2;        // floor(sqrt(sq))
    localparam int REM_W   = DIST_W + 3;      // square root partial remainder
    localparam int KP_W    = 2 * STIFF_W;     // raw stiffness product
    localparam int K_W     = KP_W - FRAC_W;   // combined stiffness, Q.16
    localparam int PX_W    = MAG_W + DIST_W;  // |d| * |dist - rest|
    localparam int MX_W    = PX_W + K_W;      // times combined stiffness
    localparam int SUM_W   = MX_W + 1;        // plus rounding term
    localparam int QUO_W   = 24;              // correction magnitude
    localparam int DVD_W   = DIST_W + QUO_W;  // dividend into the divider
    localparam int ACC_W   = POS_W + 6;       // position plus correction

    // Pipeline depths
    localparam int SQRT_STAGES = DIST_W;
    localparam int DIV_STAGES  = QUO_W;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = Q_AW + 1;

    localparam logic [STIFF_W-1:0] GSTIFF_RESET = STIFF_W'(32768);
    localparam logic [KP_W-1:0]    K_ROUND      = KP_W'(32768);

    // What the back end does with one constraint
    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_HALF,
        MODE_MOVE_A,
        MODE_MOVE_B
    } scr_mode_t;

    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic                    a_pinned;
        logic                    b_pinned;
        logic [REST_W-1:0]       rest_length;
        logic [STIFF_W-1:0]      spring_stiffness;
        logic                    spring_active;
    } scr_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
    } scr_out_t;

    // Classified constraint, as queued between front and back
    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic [REST_W-1:0]       rest;
        logic [STIFF_W-1:0]      ks;
        logic                    dx_neg;
        logic                    dy_neg;
        logic [MAG_W-1:0]        ux;
        logic [MAG_W-1:0]        uy;
        scr_mode_t               mode;
    } scr_item_t;

    // Side data carried down the back pipeline
    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic [REST_W-1:0]       rest;
        logic                    dx_neg;
        logic                    dy_neg;
        logic [MAG_W-1:0]        ux;
        logic [MAG_W-1:0]        uy;
        logic [KP_W-1:0]         kp;
        scr_mode_t               mode;
    } scr_carry_t;

    // Clamp a widened position to the Q12.8 range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (v[ACC_W-1:POS_W-1] == '0) || (v[ACC_W-1:POS_W-1] == '1);
        if (fits)
        begin
            return v[POS_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

### hdl/scr_front.sv
// Front end: input holding register and constraint classification.
// Depends on scr_pkg; feeds scr_queue.

module scr_front
    import scr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  scr_in_t   req_data,
    input  logic      q_full,
    output logic      push,
    output scr_item_t push_item
);

    logic    hold_valid_reg;
    scr_in_t hold_data_reg;

    logic                    accept;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic signed [POS_W:0]   ndx;
    logic signed [POS_W:0]   ndy;

    // Handshake with the queue
    assign accept    = req_valid && !req_stall;
    assign req_stall = hold_valid_reg && q_full;
    assign push      = hold_valid_reg && !q_full;

    // Holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_data_reg <= req_data;
        end
    end

    // Offsets, magnitudes and mode
    always_comb
    begin
        dx  = {hold_data_reg.b_x[POS_W-1], hold_data_reg.b_x}
            - {hold_data_reg.a_x[POS_W-1], hold_data_reg.a_x};
        dy  = {hold_data_reg.b_y[POS_W-1], hold_data_reg.b_y}
            - {hold_data_reg.a_y[POS_W-1], hold_data_reg.a_y};
        ndx = -dx;
        ndy = -dy;

        push_item.a_x    = hold_data_reg.a_x;
        push_item.a_y    = hold_data_reg.a_y;
        push_item.b_x    = hold_data_reg.b_x;
        push_item.b_y    = hold_data_reg.b_y;
        push_item.rest   = hold_data_reg.rest_length;
        push_item.ks     = hold_data_reg.spring_stiffness;
        push_item.dx_neg = dx[POS_W];
        push_item.dy_neg = dy[POS_W];
        push_item.ux     = dx[POS_W] ? ndx : dx;
        push_item.uy     = dy[POS_W] ? ndy : dy;

        priority if (!hold_data_reg.spring_active
                     || (hold_data_reg.a_pinned && hold_data_reg.b_pinned))
        begin
            push_item.mode = MODE_PASS;
        end
        else if (!hold_data_reg.a_pinned && !hold_data_reg.b_pinned)
        begin
            push_item.mode = MODE_HALF;
        end
        else if (!hold_data_reg.a_pinned)
        begin
            push_item.mode = MODE_MOVE_A;
        end
        else
        begin
            push_item.mode = MODE_MOVE_B;
        end
    end

endmodule

### hdl/scr_queue.sv
// Short FIFO of classified constraints between front and back.
// Depends on scr_pkg.

module scr_queue
    import scr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scr_item_t push_item,
    input  logic      pop,
    output scr_item_t pop_item,
    output logic      full,
    output logic      empty
);

    scr_item_t        entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

### hdl/scr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on scr_pkg; used by scr_back for each axis.

module scr_div
    import scr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIST_W-1:0] divisor,
    output logic [QUO_W-1:0]  quotient
);

    logic [DIST_W-1:0] rem_reg [DIV_STAGES-1];
    logic [QUO_W-1:0]  low_reg [DIV_STAGES-1];
    logic [DIST_W-1:0] dsr_reg [DIV_STAGES-1];
    logic [QUO_W-1:0]  quo_reg [DIV_STAGES];

    assign quotient = quo_reg[DIV_STAGES-1];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DIST_W-1:0] cur_rem;
        logic [QUO_W-1:0]  cur_low;
        logic [DIST_W-1:0] cur_dsr;
        logic [QUO_W-1:0]  cur_quo;
        logic [DIST_W:0]   trial;
        logic [DIST_W:0]   diff;
        logic              ge;

        if (i == 0)
        begin : g_first
            // high part already below the divisor for in-range operands
            assign cur_rem = dividend[DVD_W-1:QUO_W];
            assign cur_low = dividend[QUO_W-1:0];
            assign cur_dsr = divisor;
            assign cur_quo = '0;
        end
        else
        begin : g_next
            assign cur_rem = rem_reg[i-1];
            assign cur_low = low_reg[i-1];
            assign cur_dsr = dsr_reg[i-1];
            assign cur_quo = quo_reg[i-1];
        end

        // one restoring step
        assign trial = {cur_rem, cur_low[QUO_W-1-i]};
        assign diff  = trial - {1'b0, cur_dsr};
        assign ge    = (trial >= {1'b0, cur_dsr});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= {cur_quo[QUO_W-2:0], ge};
            end
        end

        if (i < DIV_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
                    low_reg[i] <= cur_low;
                    dsr_reg[i] <= cur_dsr;
                end
            end
        end
    end

endmodule

### hdl/scr_back.sv
// Back end: distance, stiffness scaling, correction and saturation pipeline.
// Depends on scr_pkg and scr_div; reads from scr_queue.

module scr_back
    import scr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  scr_item_t          q_item,
    output logic               pop,
    input  logic [STIFF_W-1:0] gstiff,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output scr_out_t           rsp_data
);

    typedef struct packed {
        scr_carry_t car;
        logic       nx;
        logic       ny;
        logic       zero;
    } scr_tail_t;

    logic en;

    // entry stage
    logic              s0_v_reg;
    scr_carry_t        s0_car_reg;
    logic [SQ_W-1:0]   s0_rad_reg;

    // square root stages
    logic              sq_v_reg   [SQRT_STAGES];
    scr_carry_t        sq_car_reg [SQRT_STAGES];
    logic [DIST_W-1:0] sq_root_reg[SQRT_STAGES];
    logic [REM_W-1:0]  sq_rem_reg [SQRT_STAGES-1];
    logic [SQ_W-1:0]   sq_rad_reg [SQRT_STAGES-1];

    // correction stages
    logic              d1_v_reg, d2_v_reg, d3_v_reg, d4_v_reg;
    scr_carry_t        d1_car_reg, d2_car_reg, d3_car_reg;
    scr_tail_t         d4_tail_reg;
    logic [DIST_W-1:0] d1_dist_reg, d2_dist_reg, d3_dist_reg;
    logic [DIST_W-1:0] d4_dist_reg;
    logic [DIST_W-1:0] d1_ud_reg;
    logic [K_W-1:0]    d1_k_reg, d2_k_reg;
    logic              d1_nx_reg, d1_ny_reg, d2_nx_reg, d2_ny_reg, d3_nx_reg, d3_ny_reg;
    logic [PX_W-1:0]   d2_px_reg, d2_py_reg;
    logic [MX_W-1:0]   d3_mx_reg, d3_my_reg;
    logic [DVD_W-1:0]  d4_dvx_reg, d4_dvy_reg;

    // divider side pipeline
    logic              dv_v_reg    [DIV_STAGES];
    scr_tail_t         dv_tail_reg [DIV_STAGES];
    logic [QUO_W-1:0]  quo_x, quo_y;

    logic              rsp_valid_reg;
    scr_out_t          rsp_data_reg;

    // combinational helpers
    logic [DIST_W:0]   d1_diff, d1_ndiff;
    logic [KP_W-1:0]   d1_ksum;
    logic [SUM_W-1:0]  d4_sx, d4_sy, d4_rnd;
    logic              d4_half;
    scr_tail_t         tl;
    logic signed [ACC_W-1:0] hq_x, hq_y, hx, hy;
    logic signed [ACC_W-1:0] ax_w, ay_w, bx_w, by_w;
    logic signed [ACC_W-1:0] nax, nay, nbx, nby;

    // Whole pipeline advances unless the output is held
    assign en        = !rsp_valid_reg || !rsp_stall;
    assign pop       = en && !q_empty;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg      <= 1'b0;
            d1_v_reg      <= 1'b0;
            d2_v_reg      <= 1'b0;
            d3_v_reg      <= 1'b0;
            d4_v_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg      <= pop;
            d1_v_reg      <= sq_v_reg[SQRT_STAGES-1];
            d2_v_reg      <= d1_v_reg;
            d3_v_reg      <= d2_v_reg;
            d4_v_reg      <= d3_v_reg;
            rsp_valid_reg <= dv_v_reg[DIV_STAGES-1];
        end
    end

    // Entry: squared length and raw stiffness product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_rad_reg        <= SQ_W'(q_item.ux) * SQ_W'(q_item.ux)
                               + SQ_W'(q_item.uy) * SQ_W'(q_item.uy);
            s0_car_reg.a_x    <= q_item.a_x;
            s0_car_reg.a_y    <= q_item.a_y;
            s0_car_reg.b_x    <= q_item.b_x;
            s0_car_reg.b_y    <= q_item.b_y;
            s0_car_reg.rest   <= q_item.rest;
            s0_car_reg.dx_neg <= q_item.dx_neg;
            s0_car_reg.dy_neg <= q_item.dy_neg;
            s0_car_reg.ux     <= q_item.ux;
            s0_car_reg.uy     <= q_item.uy;
            s0_car_reg.kp     <= KP_W'(q_item.ks) * KP_W'(gstiff);
            s0_car_reg.mode   <= q_item.mode;
        end
    end

    // Integer square root, two radicand bits per stage
    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        logic              cur_v;
        scr_carry_t        cur_car;
        logic [SQ_W-1:0]   cur_rad;
        logic [REM_W-1:0]  cur_rem;
        logic [DIST_W-1:0] cur_root;
        logic [REM_W-1:0]  rsh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign cur_v    = s0_v_reg;
            assign cur_car  = s0_car_reg;
            assign cur_rad  = s0_rad_reg;
            assign cur_rem  = '0;
            assign cur_root = '0;
        end
        else
        begin : g_next
            assign cur_v    = sq_v_reg[j-1];
            assign cur_car  = sq_car_reg[j-1];
            assign cur_rad  = sq_rad_reg[j-1];
            assign cur_rem  = sq_rem_reg[j-1];
            assign cur_root = sq_root_reg[j-1];
        end

        assign rsh   = {cur_rem[REM_W-3:0], cur_rad[SQ_W-1-2*j -: 2]};
        assign trial = {{(REM_W-DIST_W-2){1'b0}}, cur_root, 2'b01};
        assign ge    = (rsh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[j] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_car_reg[j]  <= cur_car;
                sq_root_reg[j] <= {cur_root[DIST_W-2:0], ge};
            end
        end

        if (j < SQRT_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[j] <= ge ? (rsh - trial) : rsh;
                    sq_rad_reg[j] <= cur_rad;
                end
            end
        end
    end

    // Stretch, its sign and the combined stiffness
    always_comb
    begin
        d1_diff  = {1'b0, sq_root_reg[SQRT_STAGES-1]}
                 - {{(DIST_W+1-REST_W){1'b0}}, sq_car_reg[SQRT_STAGES-1].rest};
        d1_ndiff = -d1_diff;
        d1_ksum  = sq_car_reg[SQRT_STAGES-1].kp + K_ROUND;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_car_reg  <= sq_car_reg[SQRT_STAGES-1];
            d1_dist_reg <= sq_root_reg[SQRT_STAGES-1];
            d1_ud_reg   <= d1_diff[DIST_W] ? d1_ndiff[DIST_W-1:0] : d1_diff[DIST_W-1:0];
            d1_nx_reg   <= sq_car_reg[SQRT_STAGES-1].dx_neg ^ d1_diff[DIST_W];
            d1_ny_reg   <= sq_car_reg[SQRT_STAGES-1].dy_neg ^ d1_diff[DIST_W];
            d1_k_reg    <= d1_ksum[KP_W-1:FRAC_W];
        end
    end

    // |d| times stretch
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_car_reg  <= d1_car_reg;
            d2_dist_reg <= d1_dist_reg;
            d2_nx_reg   <= d1_nx_reg;
            d2_ny_reg   <= d1_ny_reg;
            d2_k_reg    <= d1_k_reg;
            d2_px_reg   <= PX_W'(d1_car_reg.ux) * PX_W'(d1_ud_reg);
            d2_py_reg   <= PX_W'(d1_car_reg.uy) * PX_W'(d1_ud_reg);
        end
    end

    // times stiffness
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_car_reg  <= d2_car_reg;
            d3_dist_reg <= d2_dist_reg;
            d3_nx_reg   <= d2_nx_reg;
            d3_ny_reg   <= d2_ny_reg;
            d3_mx_reg   <= MX_W'(d2_px_reg) * MX_W'(d2_k_reg);
            d3_my_reg   <= MX_W'(d2_py_reg) * MX_W'(d2_k_reg);
        end
    end

    // Rounding offset and scale before the divide; half step uses one more bit
    always_comb
    begin
        d4_half = (d3_car_reg.mode == MODE_HALF);
        d4_rnd  = d4_half ? (SUM_W'(d3_dist_reg) << FRAC_W)
                          : (SUM_W'(d3_dist_reg) << (FRAC_W - 1));
        d4_sx   = {1'b0, d3_mx_reg} + d4_rnd;
        d4_sy   = {1'b0, d3_my_reg} + d4_rnd;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d4_tail_reg.car  <= d3_car_reg;
            d4_tail_reg.nx   <= d3_nx_reg;
            d4_tail_reg.ny   <= d3_ny_reg;
            d4_tail_reg.zero <= (d3_dist_reg == '0);
            d4_dist_reg      <= d3_dist_reg;
            d4_dvx_reg       <= d4_half ? {1'b0, d4_sx[SUM_W-1:FRAC_W+1]}
                                        : d4_sx[SUM_W-1:FRAC_W];
            d4_dvy_reg       <= d4_half ? {1'b0, d4_sy[SUM_W-1:FRAC_W+1]}
                                        : d4_sy[SUM_W-1:FRAC_W];
        end
    end

    // Dividers by the distance
    scr_div u_div_x
    (
        .clk      (clk),
        .en       (en),
        .dividend (d4_dvx_reg),
        .divisor  (d4_dist_reg),
        .quotient (quo_x)
    );

    scr_div u_div_y
    (
        .clk      (clk),
        .en       (en),
        .dividend (d4_dvy_reg),
        .divisor  (d4_dist_reg),
        .quotient (quo_y)
    );

    // Side data alongside the dividers
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_tail
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[i] <= (i == 0) ? d4_v_reg : dv_v_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_tail_reg[i] <= (i == 0) ? d4_tail_reg : dv_tail_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Apply the correction and clamp
    always_comb
    begin
        tl   = dv_tail_reg[DIV_STAGES-1];
        hq_x = {{(ACC_W-QUO_W){1'b0}}, quo_x};
        hq_y = {{(ACC_W-QUO_W){1'b0}}, quo_y};
        hx   = tl.nx ? -hq_x : hq_x;
        hy   = tl.ny ? -hq_y : hq_y;
        ax_w = {{(ACC_W-POS_W){tl.car.a_x[POS_W-1]}}, tl.car.a_x};
        ay_w = {{(ACC_W-POS_W){tl.car.a_y[POS_W-1]}}, tl.car.a_y};
        bx_w = {{(ACC_W-POS_W){tl.car.b_x[POS_W-1]}}, tl.car.b_x};
        by_w = {{(ACC_W-POS_W){tl.car.b_y[POS_W-1]}}, tl.car.b_y};
        nax  = ax_w;
        nay  = ay_w;
        nbx  = bx_w;
        nby  = by_w;
        if (!tl.zero)
        begin
            unique case (tl.car.mode)
                MODE_PASS:
                begin
                    nax = ax_w;
                end
                MODE_HALF:
                begin
                    nax = ax_w + hx;
                    nay = ay_w + hy;
                    nbx = bx_w - hx;
                    nby = by_w - hy;
                end
                MODE_MOVE_A:
                begin
                    nax = ax_w + hx;
                    nay = ay_w + hy;
                end
                MODE_MOVE_B:
                begin
                    nbx = bx_w - hx;
                    nby = by_w - hy;
                end
                default:
                begin
                    nax = ax_w;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_data_reg.new_a_x <= sat_pos(nax);
            rsp_data_reg.new_a_y <= sat_pos(nay);
            rsp_data_reg.new_b_x <= sat_pos(nbx);
            rsp_data_reg.new_b_y <= sat_pos(nby);
        end
    end

    // Checks
    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> en)
        else $error("pop while pipeline held");
    a_held_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (s0_v_reg == $past(s0_v_reg)) && (d4_v_reg == $past(d4_v_reg)))
        else $error("pipeline moved while output held");
    a_entry_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (en && pop) |=> s0_v_reg)
        else $error("popped transaction lost at entry");

endmodule

### hdl/spring_constraint_relax.sv
// Top level of the spring distance-constraint relaxation block.
// Depends on scr_pkg, scr_front, scr_queue, scr_back (and scr_div below it).
//
//  channel | signals                         | transfers when
//  --------+---------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data  | req_valid high, req_stall low
//  result  | rsp_valid, rsp_stall, rsp_data  | rsp_valid high, rsp_stall low
//  config  | cfg_wr_en, cfg_wr_data          | cfg_wr_en high
//
// One transaction per cycle sustained while rsp_stall is low; the path to the
// result holds the 21-stage square root and the 24-stage dividers.
// Reset (rst_n, async low) clears all valid bits and the queue; stiffness
// returns to 0.5. No clearing pass. A held result freezes the back pipeline,
// and the 4-entry queue then fills before req_stall rises.

module spring_constraint_relax
    import scr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  scr_in_t            req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output scr_out_t           rsp_data,
    input  logic               cfg_wr_en,
    input  logic [STIFF_W-1:0] cfg_wr_data
);

    logic [STIFF_W-1:0] gstiff_reg;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    scr_item_t          push_item;
    scr_item_t          pop_item;

    // Global stiffness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gstiff_reg <= GSTIFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            gstiff_reg <= cfg_wr_data;
        end
    end

    scr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    scr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    scr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .pop       (pop),
        .gstiff    (gstiff_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for spring_constraint_relax: drives constraint
// transactions, predicts each corrected pair of positions and checks them.
// Depends on scr_pkg and the spring_constraint_relax RTL.

module testbench;
    import scr_pkg::*;

    localparam int LATENCY   = 53;
    localparam int POS_MAX_V = 524287;
    localparam int POS_MIN_V = -524288;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    scr_in_t            req_data;
    logic               rsp_valid;
    logic               rsp_stall;
    scr_out_t           rsp_data;
    logic               cfg_wr_en;
    logic [STIFF_W-1:0] cfg_wr_data;

    // Model copy of the stiffness register
    logic [STIFF_W-1:0] gstiff;
    scr_out_t           pending_pos[$];
    int                 mismatches;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    spring_constraint_relax DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n  -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // round(mag/den) with the sign applied, ties away from zero
    function automatic longint round_div(input bit neg, input longint unsigned mag,
                                         input longint unsigned den);
        longint unsigned q;
        q = (2 * mag + den) / (2 * den);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_MAX_V)
            return POS_W'(POS_MAX_V);
        if (v < POS_MIN_V)
            return POS_W'(POS_MIN_V);
        return POS_W'(v);
    endfunction

    // Predict the relaxed positions of one constraint
    function automatic scr_out_t relax_positions(input scr_in_t c);
        longint ax, ay, bx, by, dx, dy, rest, diff, hx, hy;
        longint nax, nay, nbx, nby;
        longint unsigned ux, uy, dist_len, k, ud, mx, my, den;
        bit nx, ny;
        scr_out_t r;
        ax = longint'(c.a_x); ay = longint'(c.a_y);
        bx = longint'(c.b_x); by = longint'(c.b_y);
        rest = longint'(c.rest_length);
        dx = bx - ax; dy = by - ay;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        dist_len = isqrt(ux * ux + uy * uy);
        nax = ax; nay = ay; nbx = bx; nby = by;
        if (c.spring_active && !(c.a_pinned && c.b_pinned) && dist_len != 0)
        begin
            k    = (longint'(c.spring_stiffness) * longint'(gstiff) + 32768) >> 16;
            diff = longint'(dist_len) - rest;
            ud   = diff < 0 ? -diff : diff;
            nx   = (dx < 0) != (diff < 0);
            ny   = (dy < 0) != (diff < 0);
            mx   = ux * ud * k;
            my   = uy * ud * k;
            den  = dist_len << 16;
            if (!c.a_pinned && !c.b_pinned)
            begin
                hx = round_div(nx, mx, den * 2);
                hy = round_div(ny, my, den * 2);
                nax = ax + hx; nay = ay + hy;
                nbx = bx - hx; nby = by - hy;
            end
            else
            begin
                hx = round_div(nx, mx, den);
                hy = round_div(ny, my, den);
                if (!c.a_pinned)
                begin
                    nax = ax + hx; nay = ay + hy;
                end
                else
                begin
                    nbx = bx - hx; nby = by - hy;
                end
            end
        end
        r.new_a_x = clamp_pos(nax);
        r.new_a_y = clamp_pos(nay);
        r.new_b_x = clamp_pos(nbx);
        r.new_b_y = clamp_pos(nby);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Result side: random stall and per-field comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_pos.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    scr_out_t e;
                    e = pending_pos.pop_front();
                    if (rsp_data.new_a_x !== e.new_a_x)
                        report_mismatch("new_a_x", rsp_data.new_a_x, e.new_a_x);
                    if (rsp_data.new_a_y !== e.new_a_y)
                        report_mismatch("new_a_y", rsp_data.new_a_y, e.new_a_y);
                    if (rsp_data.new_b_x !== e.new_b_x)
                        report_mismatch("new_b_x", rsp_data.new_b_x, e.new_b_x);
                    if (rsp_data.new_b_y !== e.new_b_y)
                        report_mismatch("new_b_y", rsp_data.new_b_y, e.new_b_y);
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Send one transaction, with random idle cycles before it
    task automatic send_constraint(input scr_in_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= c;
        pending_pos.push_back(relax_positions(c));
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic go_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_gstiff(input logic [STIFF_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        gstiff = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic scr_in_t make_constraint(input int ax, input int ay, input int bx,
                                                input int by, input bit ap, input bit bp,
                                                input int rest, input int ks, input bit act);
        scr_in_t c;
        c.a_x = POS_W'(ax); c.a_y = POS_W'(ay);
        c.b_x = POS_W'(bx); c.b_y = POS_W'(by);
        c.a_pinned = ap; c.b_pinned = bp;
        c.rest_length = REST_W'(rest);
        c.spring_stiffness = STIFF_W'(ks);
        c.spring_active = act;
        return c;
    endfunction

    function automatic scr_in_t random_constraint();
        scr_in_t c;
        int span;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(scr_in_t)-1:0];
        // Mostly nearby particles so corrections stay in range
        if ($urandom_range(3) != 0)
        begin
            span = 1 << $urandom_range(18, 4);
            c.b_x = c.a_x + POS_W'($urandom_range(2 * span) - span);
            c.b_y = c.a_y + POS_W'($urandom_range(2 * span) - span);
            c.rest_length = REST_W'($urandom_range(2 * span));
            c.spring_active = ($urandom_range(9) != 0);
            c.spring_stiffness = STIFF_W'($urandom_range(65536));
        end
        if ($urandom_range(20) == 0)
            c.spring_stiffness = '1;
        return c;
    endfunction

    task automatic test_directed();
        send_constraint(make_constraint(0, 0, 2560, 0, 0, 0, 1280, 65536, 1));
        send_constraint(make_constraint(0, 0, 2560, 0, 1, 0, 1280, 65536, 1));
        send_constraint(make_constraint(0, 0, 0, 2560, 0, 1, 5120, 65536, 1));
        send_constraint(make_constraint(0, 0, 2560, 2560, 1, 1, 0, 65536, 1));
        send_constraint(make_constraint(0, 0, 2560, 2560, 0, 0, 0, 65536, 0));
        send_constraint(make_constraint(777, -55, 777, -55, 0, 0, 100, 65536, 1));
        send_constraint(make_constraint(POS_MIN_V, POS_MIN_V, POS_MAX_V, POS_MAX_V,
                                        0, 1, 0, 131071, 1));
        send_constraint(make_constraint(POS_MAX_V, POS_MAX_V, POS_MIN_V, POS_MIN_V,
                                        1, 0, 0, 131071, 1));
        send_constraint(make_constraint(POS_MAX_V, 0, POS_MIN_V, 0, 0, 0, 524287, 0, 1));
        send_constraint(make_constraint(0, POS_MIN_V, 0, POS_MAX_V, 0, 0, 524287, 65536, 1));
        send_constraint(make_constraint(-3, 4, 0, 0, 0, 0, 0, 65536, 1));
        send_constraint(make_constraint(1, 1, -1, -1, 0, 1, 0, 1, 1));
        send_constraint(make_constraint(100, 0, 101, 0, 0, 0, 524287, 131071, 1));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_constraint(random_constraint());
    endtask

    task automatic test_stiffness_sweep();
        logic [STIFF_W-1:0] settings[5];
        settings = '{STIFF_W'(0), STIFF_W'(65536), STIFF_W'(131071), STIFF_W'(1),
                     STIFF_W'(32768)};
        foreach (settings[i])
        begin
            write_gstiff(settings[i]);
            test_directed();
            test_random(80);
            go_idle();
        end
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        gstiff = GSTIFF_RESET;
        mismatches = 0;
        send_idle_pct = 9;
        recv_idle_pct = 68;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        go_idle();
        send_idle_pct = 68;
        recv_idle_pct = 9;
        test_stiffness_sweep();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_gstiff(STIFF_W'($urandom_range(131071)));
        test_random(720);
        go_idle();
        if (mismatches == 0 && pending_pos.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end
endmodule
